@@ design/hsb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsb_pkg - shared types and constants for the height-field shader blend
// Widths, operator codes, rounding constants and the stage payload structs.
// ----------------------------------------------------------------------------
package hsb_pkg;

  localparam int HEIGHT_BITS      = 24;
  localparam int WEIGHT_FRAC_BITS = 15;
  localparam int WIN_W            = 16;
  localparam int OP_W             = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = HEIGHT_BITS;
  localparam int NB_N             = 4;
  localparam int CNT_W            = 3;
  localparam int PIPE_LAT         = 7;

  // clamped weight and its complement scaled by up to four neighbours
  localparam int W_W   = WEIGHT_FRAC_BITS + 1;
  localparam int K_W   = WEIGHT_FRAC_BITS + 3;
  localparam int SUM_W = HEIGHT_BITS + 2;

  // product widths
  localparam int P_W   = HEIGHT_BITS + W_W + 1;
  localparam int HK_W  = HEIGHT_BITS + K_W + 1;
  localparam int WS_W  = SUM_W + W_W + 1;
  localparam int WW_W  = 2 * W_W;
  localparam int QA_W  = HEIGHT_BITS + WW_W + 1;

  // unrounded numerator and the value after the power-of-two shift
  localparam int NUM_W = HEIGHT_BITS + WEIGHT_FRAC_BITS + 5;
  localparam int XW    = NUM_W - WEIGHT_FRAC_BITS;

  // divide by three: bias to non-negative, multiply by a rounded-up reciprocal
  localparam int UW      = XW + 2;
  localparam int MW      = UW + 1;
  localparam int PROD_W  = UW + MW;
  localparam int DIV3_SH = UW + 2;
  localparam logic [63:0]   DIV3_M_FULL = ((64'd1 << DIV3_SH) + 64'd2) / 64'd3;
  localparam logic [MW-1:0] DIV3_M      = DIV3_M_FULL[MW-1:0];
  localparam logic [UW-1:0] DIV3_BIAS   = UW'(3) << (XW - 1);
  localparam logic [XW:0]   DIV3_OFS    = (XW + 1)'(1) << (XW - 1);

  localparam logic [W_W-1:0] ONE_W = W_W'(1) << WEIGHT_FRAC_BITS;

  localparam logic signed [NUM_W-1:0] RND_HALF       = NUM_W'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic signed [NUM_W-1:0] RND_ONE        = NUM_W'(1) << WEIGHT_FRAC_BITS;
  localparam logic signed [NUM_W-1:0] RND_TWO        = NUM_W'(1) << (WEIGHT_FRAC_BITS + 1);
  localparam logic signed [NUM_W-1:0] RND_THREE_HALF = NUM_W'(3) << (WEIGHT_FRAC_BITS - 1);

  localparam logic signed [XW-1:0] HMAX_X = XW'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] HMIN_X = XW'(-(64'sd1 <<< (HEIGHT_BITS - 1)));

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_MAX      = 4'd1,
    OP_MIN      = 4'd2,
    OP_MULTIPLY = 4'd3,
    OP_REPLACE  = 4'd4,
    OP_SUBTRACT = 4'd5,
    OP_FILTER   = 4'd6,
    OP_SMOOTH   = 4'd7,
    OP_AVERAGE  = 4'd8
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_SELECT     = 1'b0,
    CFG_HEIGHT_AMOUNT = 1'b1
  } cfg_idx_e;

  // final divisor as a power of two: one, two or four times the weight unit
  typedef enum logic [1:0] {
    SH_ONE,
    SH_TWO,
    SH_FOUR
  } shift_e;

  typedef struct packed {
    op_e                     op;
    logic                    smooth_en;
    logic [CNT_W-1:0]        cnt;
    logic [HEIGHT_BITS-1:0]  h;
    logic [P_W-1:0]          p;
    logic [HK_W-1:0]         hk;
    logic [WW_W-1:0]         ww;
    logic [WS_W-1:0]         ws;
  } s2_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    shift_e           sh;
    logic             div3;
  } s4_t;

endpackage

@@ design/hsb_front.sv @@
// ----------------------------------------------------------------------------
// hsb_front - operand preparation and product stage
// Clamps weights, sums present neighbours, then forms the height products.
// ----------------------------------------------------------------------------
module hsb_front import hsb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  op_e                           op_i,
  input  logic signed [HEIGHT_BITS-1:0] amount_i,
  input  logic signed [HEIGHT_BITS-1:0] h_i,
  input  logic signed [HEIGHT_BITS-1:0] nb_i [NB_N],
  input  logic [NB_N-1:0]               has_i,
  input  logic [WIN_W-1:0]              shader_i,
  input  logic [WIN_W-1:0]              effect_i,
  output logic                          valid_o,
  output s2_t                           s2_o
);

  function automatic logic [W_W-1:0] clamp_w(input logic [WIN_W-1:0] v);
    logic gt;
    gt = {1'b0, v} > ((WIN_W + 1)'(1) << WEIGHT_FRAC_BITS);
    return gt ? ONE_W : W_W'(v);
  endfunction

  logic [W_W-1:0]          w_d, e_d, wsel_d;
  logic [K_W-1:0]          k_d, kb_d;
  logic signed [SUM_W-1:0] sum_d;
  logic [CNT_W-1:0]        cnt_d;
  logic                    en_d;

  logic                          v1_q;
  op_e                           op1_q;
  logic signed [HEIGHT_BITS-1:0] h1_q;
  logic [W_W-1:0]                w1_q, wsel1_q;
  logic [K_W-1:0]                k1_q;
  logic signed [SUM_W-1:0]       sum1_q;
  logic [CNT_W-1:0]              cnt1_q;
  logic                          en1_q;

  logic signed [P_W-1:0]  p_d;
  logic signed [HK_W-1:0] hk_d;
  logic [WW_W-1:0]        ww_d;
  logic signed [WS_W-1:0] ws_d;
  logic                   v2_q;
  s2_t                    s2_q;

  // stage 1: weights, neighbour sum, multiplier operand selection
  always_comb begin
    w_d   = clamp_w(shader_i);
    e_d   = clamp_w(effect_i);
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < NB_N; i++) begin
      if (has_i[i]) begin
        sum_d = sum_d + SUM_W'(nb_i[i]);
        cnt_d = cnt_d + CNT_W'(1);
      end
    end
    en_d   = (w_d != '0) && (cnt_d >= CNT_W'(2));
    kb_d   = K_W'(ONE_W - w_d);
    wsel_d = (op_i == OP_AVERAGE) ? e_d : w_d;
    case (op_i)
      OP_AVERAGE: k_d = (K_W'(ONE_W) << 1) - K_W'(e_d);
      OP_SMOOTH: begin
        if (cnt_d == CNT_W'(4)) begin
          k_d = kb_d << 2;
        end else if (cnt_d == CNT_W'(3)) begin
          k_d = kb_d + (kb_d << 1);
        end else begin
          k_d = kb_d << 1;
        end
      end
      default: k_d = kb_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_i;
    h1_q    <= h_i;
    w1_q    <= w_d;
    wsel1_q <= wsel_d;
    k1_q    <= k_d;
    sum1_q  <= sum_d;
    cnt1_q  <= cnt_d;
    en1_q   <= en_d;
  end

  // stage 2: parallel products
  always_comb begin
    p_d  = $signed({1'b0, w1_q}) * amount_i;
    hk_d = h1_q * $signed({1'b0, k1_q});
    ww_d = w1_q * wsel1_q;
    ws_d = $signed({1'b0, w1_q}) * sum1_q;
  end

  always_ff @(posedge clk_i) begin
    s2_q.op        <= op1_q;
    s2_q.smooth_en <= en1_q;
    s2_q.cnt       <= cnt1_q;
    s2_q.h         <= h1_q;
    s2_q.p         <= p_d;
    s2_q.hk        <= hk_d;
    s2_q.ww        <= ww_d;
    s2_q.ws        <= ws_d;
  end

  assign valid_o = v2_q;
  assign s2_o    = s2_q;

endmodule

@@ design/hsb_combine.sv @@
// ----------------------------------------------------------------------------
// hsb_combine - operator selection and numerator assembly
// Builds the unrounded numerator per operator and folds in the weight-squared term.
// ----------------------------------------------------------------------------
module hsb_combine import hsb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  s2_t                           s2_i,
  input  logic signed [HEIGHT_BITS-1:0] amount_i,
  output logic                          valid_o,
  output s4_t                           s4_o
);

  logic signed [NUM_W-1:0] hx, px, hkx, wsx, num_d;
  shift_e                  sh_d;
  logic                    div3_d, useqa_d;
  logic signed [QA_W-1:0]  qa_d;

  logic                    v3_q, v4_q;
  logic signed [NUM_W-1:0] num3_q;
  shift_e                  sh3_q;
  logic                    div3_3_q, useqa3_q;
  logic signed [QA_W-1:0]  qa3_q;
  logic signed [NUM_W-1:0] qs, num4_d;
  s4_t                     s4_q;

  // stage 3: per-operator numerator; rounding constant included
  always_comb begin
    hx      = NUM_W'($signed(s2_i.h)) <<< WEIGHT_FRAC_BITS;
    px      = NUM_W'($signed(s2_i.p));
    hkx     = NUM_W'($signed(s2_i.hk));
    wsx     = NUM_W'($signed(s2_i.ws));
    num_d   = hx;
    sh_d    = SH_ONE;
    div3_d  = 1'b0;
    useqa_d = 1'b0;
    case (s2_i.op)
      OP_ADD:      num_d = hx + px + RND_HALF;
      OP_SUBTRACT: num_d = hx - px + RND_HALF;
      OP_REPLACE:  num_d = px + RND_HALF;
      OP_MULTIPLY: num_d = hx - hkx + RND_HALF;
      OP_MAX:      num_d = (hx < px) ? px + RND_HALF : hx;
      OP_MIN:      num_d = (hx > px) ? px + RND_HALF : hx;
      OP_FILTER: begin
        num_d   = hkx + RND_HALF;
        useqa_d = 1'b1;
      end
      OP_AVERAGE: begin
        num_d   = hkx + RND_ONE;
        sh_d    = SH_TWO;
        useqa_d = 1'b1;
      end
      OP_SMOOTH: begin
        if (s2_i.smooth_en) begin
          if (s2_i.cnt == CNT_W'(2)) begin
            num_d = hkx + wsx + RND_ONE;
            sh_d  = SH_TWO;
          end else if (s2_i.cnt == CNT_W'(3)) begin
            num_d  = hkx + wsx + RND_THREE_HALF;
            div3_d = 1'b1;
          end else begin
            num_d = hkx + wsx + RND_TWO;
            sh_d  = SH_FOUR;
          end
        end
      end
      default: num_d = hx;
    endcase
    qa_d = $signed({1'b0, s2_i.ww}) * amount_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num3_q   <= num_d;
    sh3_q    <= sh_d;
    div3_3_q <= div3_d;
    useqa3_q <= useqa_d;
    qa3_q    <= qa_d;
  end

  // stage 4: add floor(w*w*A / one) or floor(w*e*A / one)
  always_comb begin
    qs     = NUM_W'(qa3_q >>> WEIGHT_FRAC_BITS);
    num4_d = num3_q + (useqa3_q ? qs : '0);
  end

  always_ff @(posedge clk_i) begin
    s4_q.num  <= num4_d;
    s4_q.sh   <= sh3_q;
    s4_q.div3 <= div3_3_q;
  end

  assign valid_o = v4_q;
  assign s4_o    = s4_q;

endmodule

@@ design/hsb_round.sv @@
// ----------------------------------------------------------------------------
// hsb_round - final division, rounding and saturation
// Shifts by the power-of-two divisor, divides by three where needed, clamps.
// ----------------------------------------------------------------------------
module hsb_round import hsb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  s4_t                           s4_i,
  output logic                          done_o,
  output logic signed [HEIGHT_BITS-1:0] result_o,
  output logic                          sat_o
);

  logic signed [NUM_W-1:0]  shifted;
  logic signed [XW-1:0]     x_d;
  logic [UW-1:0]            u_d;
  logic                     v5_q, v6_q, v7_q;
  logic signed [XW-1:0]     x5_q, x6_q;
  logic [UW-1:0]            u5_q;
  logic                     div3_5_q, div3_6_q;
  logic [PROD_W-1:0]        prod_d, prod6_q;
  logic [PROD_W-1:0]        q_full;
  logic [XW-1:0]            q;
  logic [XW:0]              q_ofs;
  logic signed [XW-1:0]     r;
  logic signed [XW-1:0]     res_d;
  logic                     sat_d;
  logic signed [XW-1:0]     res_q;
  logic                     sat_q;

  // stage 5: floor by the power-of-two part of the divisor
  always_comb begin
    case (s4_i.sh)
      SH_ONE:  shifted = $signed(s4_i.num) >>> WEIGHT_FRAC_BITS;
      SH_TWO:  shifted = $signed(s4_i.num) >>> (WEIGHT_FRAC_BITS + 1);
      SH_FOUR: shifted = $signed(s4_i.num) >>> (WEIGHT_FRAC_BITS + 2);
      default: shifted = $signed(s4_i.num) >>> WEIGHT_FRAC_BITS;
    endcase
    x_d = shifted[XW-1:0];
    u_d = UW'(x_d) + DIV3_BIAS;
  end

  // stage 6: reciprocal multiply
  assign prod_d = u5_q * DIV3_M;

  // stage 7: remove the bias, then clamp
  always_comb begin
    q_full = prod6_q >> DIV3_SH;
    q      = q_full[XW-1:0];
    q_ofs  = {1'b0, q} - DIV3_OFS;
    r      = div3_6_q ? $signed(q_ofs[XW-1:0]) : x6_q;
    sat_d  = 1'b0;
    res_d  = r;
    if (r > HMAX_X) begin
      res_d = HMAX_X;
      sat_d = 1'b1;
    end else if (r < HMIN_X) begin
      res_d = HMIN_X;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x5_q     <= x_d;
    u5_q     <= u_d;
    div3_5_q <= s4_i.div3;
    x6_q     <= x5_q;
    prod6_q  <= prod_d;
    div3_6_q <= div3_5_q;
    res_q    <= res_d;
    sat_q    <= sat_d;
  end

  assign done_o   = v7_q;
  assign result_o = res_q[HEIGHT_BITS-1:0];
  assign sat_o    = sat_q;

endmodule

@@ design/heightfield_shader_blend_core.sv @@
// ----------------------------------------------------------------------------
// heightfield_shader_blend_core - per-vertex height and shader weight blend
// Seven-stage pipeline applying one of nine blend operators to a vertex height.
// ----------------------------------------------------------------------------
// Usage: the core takes one vertex per clock. busy_o never rises, so a vertex
// is transferred on every cycle that start_i is high. Its result is shown on
// result_height_o / saturated_o with done_o high for one cycle only, once the
// vertex has left the last of the seven register stages. There is no
// back-pressure: the receiver must take each result in the cycle it is shown.
// The register stages are, in order: operand prep, the height and
// weight products, operator select together with the weight-squared product,
// adding the scaled weight-squared term, the power-of-two shift, the divide-by-
// three reciprocal multiply, and the clamp. The products of stage two run
// side by side, so no stage chains one multiplier into another. Write
// op_select and height_amount only while no vertex is in flight, that is, at
// least seven cycles after the last transfer.
module heightfield_shader_blend_core import hsb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  // vertex input
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [HEIGHT_BITS-1:0] center_height_i,
  input  logic signed [HEIGHT_BITS-1:0] height_prev_u_i,
  input  logic signed [HEIGHT_BITS-1:0] height_next_u_i,
  input  logic signed [HEIGHT_BITS-1:0] height_prev_v_i,
  input  logic signed [HEIGHT_BITS-1:0] height_next_v_i,
  input  logic                          has_prev_u_i,
  input  logic                          has_next_u_i,
  input  logic                          has_prev_v_i,
  input  logic                          has_next_v_i,
  input  logic [WIN_W-1:0]              shader_value_i,
  input  logic [WIN_W-1:0]              effect_value_i,
  // result
  output logic                          done_o,
  output logic signed [HEIGHT_BITS-1:0] result_height_o,
  output logic                          saturated_o
);

  op_e                           op_q;
  logic signed [HEIGHT_BITS-1:0] amount_q;
  logic                          accept;
  logic signed [HEIGHT_BITS-1:0] nb [NB_N];
  logic [NB_N-1:0]               has;
  logic                          v2, v4;
  s2_t                           s2;
  s4_t                           s4;

  // Config registers. Both reset to zero: add with a zero amount.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_ADD;
      amount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OP_SELECT:     op_q     <= op_e'(cfg_wdata_i[OP_W-1:0]);
        CFG_HEIGHT_AMOUNT: amount_q <= $signed(cfg_wdata_i[HEIGHT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so always ready for a transfer.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Neighbour order: previous u, next u, previous v, next v.
  assign nb[0]  = height_prev_u_i;
  assign nb[1]  = height_next_u_i;
  assign nb[2]  = height_prev_v_i;
  assign nb[3]  = height_next_v_i;
  assign has    = {has_next_v_i, has_prev_v_i, has_next_u_i, has_prev_u_i};

  // Stages 1-2: clamp weights, neighbour sum, products with height and amount.
  hsb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .op_i     (op_q),
    .amount_i (amount_q),
    .h_i      (center_height_i),
    .nb_i     (nb),
    .has_i    (has),
    .shader_i (shader_value_i),
    .effect_i (effect_value_i),
    .valid_o  (v2),
    .s2_o     (s2)
  );

  // Stages 3-4: choose the operator's numerator and its final divisor.
  hsb_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2),
    .s2_i     (s2),
    .amount_i (amount_q),
    .valid_o  (v4),
    .s4_o     (s4)
  );

  // Stages 5-7: floor division, exact divide by three for smooth over three
  // neighbours, and saturation to the height range.
  hsb_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v4),
    .s4_i     (s4),
    .done_o   (done_o),
    .result_o (result_height_o),
    .sat_o    (saturated_o)
  );

  // A result only ever follows a transfer by the pipeline latency.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, PIPE_LAT))
    else $error("result strobe without a matching input transfer");

  // A clamped result sits on one of the two rails.
  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      (result_height_o == HMAX_X[HEIGHT_BITS-1:0]) ||
      (result_height_o == HMIN_X[HEIGHT_BITS-1:0]))
    else $error("saturated result not at a range limit");

  // Unused operator codes pass the height through unclamped.
  a_unused_op_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(op_q, PIPE_LAT) > OP_AVERAGE) |->
      (result_height_o == $past(center_height_i, PIPE_LAT)) && !saturated_o)
    else $error("unused operator did not pass the height through");

  // Max never lowers the height.
  a_max_not_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(op_q, PIPE_LAT) == OP_MAX) |->
      result_height_o >= $past(center_height_i, PIPE_LAT))
    else $error("max operator returned a height below the input");

endmodule
